// ===== rtl/ilq_pkg.sv =====
`timescale 1ns / 1ps

package ilq_pkg;

  // Operation codes carried by the operation field.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  // Commands broadcast to every cell of the row. Both are only raised
  // for a legal operation on an accepted transaction.
  typedef struct packed {
    logic insert_en;
    logic remove_en;
  } cell_cmd_t;

endpackage

// ===== rtl/ilq_cell.sv =====
`timescale 1ns / 1ps

module ilq_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = 32,
  parameter int PW         = 5,
  parameter int CNT_W      = 5
) (
  input  logic                  clk,
  input  ilq_pkg::cell_cmd_t    cmd,
  input  logic [PW-1:0]         position,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic [DATA_WIDTH-1:0] next_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] hit_word,
  output logic                  match
);
  import ilq_pkg::*;

  logic                  at_pos;
  logic                  above_pos;
  logic                  live;
  logic [DATA_WIDTH-1:0] data_next;

  assign at_pos    = (position == PW'(INDEX));
  assign above_pos = (position < PW'(INDEX));
  assign live      = (CNT_W'(INDEX) < count);

  // Insert pulls the lower neighbor up; remove pulls the upper neighbor down.
  always_comb begin
    data_next = data;
    if (cmd.insert_en) begin
      if (above_pos) begin
        data_next = prev_data;
      end else if (at_pos) begin
        data_next = key;
      end
    end else if (cmd.remove_en) begin
      if (above_pos || at_pos) begin
        data_next = next_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign hit_word = at_pos ? data : '0;
  assign match    = live && (data == key);

endmodule

// ===== rtl/ilq_reduce.sv =====
`timescale 1ns / 1ps

module ilq_reduce #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4
) (
  input  logic [CAPACITY-1:0]   match,
  input  logic [DATA_WIDTH-1:0] hit_words [CAPACITY],
  output logic                  any_match,
  output logic [IDX_W-1:0]      first_index,
  output logic [DATA_WIDTH-1:0] word
);

  logic [CAPACITY-1:0] lowest;

  // Two's complement trick isolates the lowest set match bit.
  assign lowest    = match & (~match + CAPACITY'(1));
  assign any_match = |match;

  always_comb begin
    first_index = '0;
    word        = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lowest[i]) begin
        first_index = first_index | IDX_W'(i);
      end
      word = word | hit_words[i];
    end
  end

endmodule

// ===== rtl/indexed_list_queue.sv =====
`timescale 1ns / 1ps
// Ordered list of words held in a row of shift cells.
// Timing: the result of a transaction is registered and offered in the cycle
// after acceptance. Throughput: one transaction per cycle; every operation
// updates the whole cell row at once, and the next input is taken
// whenever the result register is empty or being drained.
// Reset: rst clears the entry count and the result valid; entries stay as is.

module indexed_list_queue #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ilq_pkg::op_t       operation,
  input  logic [4:0]         position,
  input  logic [31:0]        value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ok,
  output logic [31:0]        data_out,
  output logic [3:0]         found_position,
  output logic [4:0]         count
);
  import ilq_pkg::*;

  // Widths derived from the configuration. Comparisons on position and
  // count are done at the wider of the port width and the count width.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int PW    = (CNT_W > 5) ? CNT_W : 5;
  localparam int VW    = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int FW    = (IDX_W > 4) ? IDX_W : 4;

  logic [CNT_W-1:0]      entry_count;
  logic [CNT_W-1:0]      entry_count_next;

  logic                  in_fire;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         cnt_w;
  logic                  insert_legal;
  logic                  index_legal;
  logic [VW-1:0]         value_ext;
  logic [DATA_WIDTH-1:0] key;
  cell_cmd_t             cmd;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] hit_words [CAPACITY];
  logic [CAPACITY-1:0]   match;

  logic                  any_match;
  logic [IDX_W-1:0]      first_index;
  logic [DATA_WIDTH-1:0] sel_word;
  logic [VW-1:0]         sel_word_ext;
  logic [FW-1:0]         first_index_ext;
  logic [PW-1:0]         cnt_next_ext;
  logic [PW-1:0]         cnt_ext;

  logic                  ok_next;
  logic [31:0]           data_out_next;
  logic [3:0]            found_position_next;

  // A new transaction is taken whenever the result register is free or
  // its contents leave in this same cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign pos_w        = PW'(position);
  assign cnt_w        = PW'(entry_count);
  assign insert_legal = (pos_w <= cnt_w) && (entry_count != CNT_W'(CAPACITY));
  assign index_legal  = (pos_w < cnt_w);

  // The input word is cut or zero-extended to the stored word width.
  assign value_ext = VW'(value);
  assign key       = value_ext[DATA_WIDTH-1:0];

  assign cmd.insert_en = in_fire && (operation == OP_INSERT) && insert_legal;
  assign cmd.remove_en = in_fire && (operation == OP_REMOVE) && index_legal;

  // The cell row. Each cell sees its two neighbors; the first cell's lower input
  // is never selected, and the last cell's upper input is its own word.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data;
    logic [DATA_WIDTH-1:0] next_data;

    if (g == 0) begin : g_first
      assign prev_data = key;
    end else begin : g_mid
      assign prev_data = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[g];
    end else begin : g_inner
      assign next_data = cell_data[g+1];
    end

    ilq_cell #(
      .INDEX      (g),
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .position  (pos_w),
      .count     (entry_count),
      .key       (key),
      .prev_data (prev_data),
      .next_data (next_data),
      .data      (cell_data[g]),
      .hit_word  (hit_words[g]),
      .match     (match[g])
    );
  end

  ilq_reduce #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_reduce (
    .match       (match),
    .hit_words   (hit_words),
    .any_match   (any_match),
    .first_index (first_index),
    .word        (sel_word)
  );

  assign sel_word_ext    = VW'(sel_word);
  assign first_index_ext = FW'(first_index);

  // Result of the offered transaction. Failed operations return zeros
  // and leave the count alone.
  always_comb begin
    ok_next             = 1'b0;
    data_out_next       = '0;
    found_position_next = '0;
    entry_count_next    = entry_count;
    case (operation)
      OP_INSERT: begin
        if (insert_legal) begin
          ok_next          = 1'b1;
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      OP_READ: begin
        if (index_legal) begin
          ok_next       = 1'b1;
          data_out_next = sel_word_ext[31:0];
        end
      end
      OP_REMOVE: begin
        if (index_legal) begin
          ok_next          = 1'b1;
          data_out_next    = sel_word_ext[31:0];
          entry_count_next = entry_count - CNT_W'(1);
        end
      end
      OP_SEARCH: begin
        if (any_match) begin
          ok_next             = 1'b1;
          found_position_next = first_index_ext[3:0];
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  assign cnt_next_ext = PW'(entry_count_next);
  assign cnt_ext      = PW'(entry_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        entry_count <= entry_count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_fire) begin
      ok             <= ok_next;
      data_out       <= data_out_next;
      found_position <= found_position_next;
      count          <= cnt_next_ext[4:0];
    end
  end

  // While a result is offered, the reported count matches the live entry count.
  a_count_tracks : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count == cnt_ext[4:0]))
    else $error("reported count differs from entry count");

  // A successful insert grows the list by exactly one entry.
  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    cmd.insert_en |=> (entry_count == $past(entry_count) + CNT_W'(1)))
    else $error("insert did not grow the list by one");

  // The entry count never exceeds the capacity.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A failed operation returns zero data and zero position.
  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> ((data_out == '0) && (found_position == '0)))
    else $error("failed operation returned nonzero payload");

  // Insert and remove are never commanded together.
  a_cmd_excl : assert property (@(posedge clk) disable iff (rst)
    !(cmd.insert_en && cmd.remove_en))
    else $error("insert and remove raised together");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ilq_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int STALL_LIMIT = 2000;

  // One result word as the list returns it.
  typedef struct packed {
    logic        ok;
    logic [31:0] data_out;
    logic [3:0]  found_position;
    logic [4:0]  count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  op_t         operation = OP_INSERT;
  logic [4:0]  position = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ok;
  logic [31:0] data_out;
  logic [3:0]  found_position;
  logic [4:0]  count;

  // Shadow copy of the list, updated once per accepted transaction.
  logic [31:0]  list_words [LIST_DEPTH];
  int unsigned  list_len = 0;
  list_result_t pending_results [$];

  int error_count = 0;
  int gap_percent = 0;
  int stall_percent = 0;
  int holdoff_request = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;

  indexed_list_queue dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .position       (position),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .data_out       (data_out),
    .found_position (found_position),
    .count          (count)
  );

  always #10 clk = ~clk;

  // Applies one operation to the shadow list and returns the result the block
  // must produce for it. Failing operations leave the list untouched.
  function automatic list_result_t apply_list_op(op_t op, logic [4:0] pos, logic [31:0] val);
    list_result_t r;
    int i;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (pos <= list_len && list_len < LIST_DEPTH) begin
          for (i = list_len; i > pos; i--) list_words[i] = list_words[i - 1];
          list_words[pos[3:0]] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (pos < list_len) begin
          r.data_out = list_words[pos[3:0]];
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < list_len) begin
          r.data_out = list_words[pos[3:0]];
          for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      OP_SEARCH: begin
        // The lowest matching position wins when a value is stored twice.
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] == val) begin
            r.ok = 1'b1;
            r.found_position = i[3:0];
            break;
          end
        end
      end
      default: ;
    endcase
    r.count = list_len[4:0];
    return r;
  endfunction

  // Both handshakes are sampled here, with the values that stood before the
  // edge. The input side is predicted first so that a result can never be
  // checked ahead of the transaction that caused it.
  always @(posedge clk) begin : result_monitor
    list_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) pending_results.push_back(apply_list_op(operation, position, value));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing outstanding");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, ok);
            error_count++;
          end
          if (data_out !== want.data_out) begin
            $error("data_out: expected %h, got %h", want.data_out, data_out);
            error_count++;
          end
          if (found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d", want.found_position, found_position);
            error_count++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            error_count++;
          end
        end
      end
    end
  end

  // Receiver side. A hold-off request from a test blocks the output for a
  // fixed stretch; otherwise the output stalls at random at the phase's rate.
  always @(posedge clk) begin
    if (holdoff_request != 0) begin
      holdoff_left = holdoff_request;
      holdoff_request = 0;
    end
    if (holdoff_left > 0) begin
      out_ready <= 1'b0;
      holdoff_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_percent);
    end
  end

  // Ends the run if the block stops moving transactions in either direction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL indexed_list_queue");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one transaction, after a random gap at the phase's idle rate, and
  // returns at the edge where it is accepted. Valid stays high on return so
  // that back-to-back transactions need no bubble.
  task automatic send_item(input op_t op, input logic [4:0] pos, input logic [31:0] val);
    while ($urandom_range(99) < gap_percent) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drops valid and waits until every expected result has come back, then idles
  // on to cover the result register. The first edge lets the monitor record the
  // last accepted transaction before the queue is read.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Empty-list failures, inserts at the front, the middle and the end,
  // duplicate values, searches with and without a hit, out-of-range reads and
  // removes, and removes from the middle, the front and the end.
  task automatic test_empty_list_edges();
    gap_percent = 0;
    stall_percent = 0;
    send_item(OP_READ, 5'd0, 32'h0);
    send_item(OP_REMOVE, 5'd0, 32'h0);
    send_item(OP_SEARCH, 5'd0, 32'h0);
    send_item(OP_INSERT, 5'd1, 32'h1111_1111);
    send_item(OP_INSERT, 5'd0, 32'h0000_0000);
    send_item(OP_INSERT, 5'd1, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 5'd1, 32'h5A5A_5A5A);
    send_item(OP_INSERT, 5'd3, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 5'd31, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 5'd0, 32'h1234_5678);
    send_item(OP_READ, 5'd2, 32'hFFFF_FFFF);
    send_item(OP_READ, 5'd4, 32'h0);
    send_item(OP_READ, 5'd31, 32'h0);
    send_item(OP_REMOVE, 5'd31, 32'h0);
    send_item(OP_REMOVE, 5'd1, 32'h0);
    send_item(OP_REMOVE, 5'd0, 32'h0);
    send_item(OP_REMOVE, 5'd1, 32'h0);
    wait_for_results();
  endtask

  // Empties the list, fills it to capacity, then tries inserts while full,
  // reads past the end, a search that hits the top entry and a few removes.
  task automatic test_full_list();
    int n;
    int i;
    n = list_len;
    repeat (n) send_item(OP_REMOVE, 5'd0, 32'h0);
    for (i = 0; i < LIST_DEPTH; i++) send_item(OP_INSERT, i[4:0], (i + 1) * 32'h1111_1111);
    send_item(OP_INSERT, 5'd16, 32'hDEAD_BEEF);
    send_item(OP_INSERT, 5'd0, 32'hDEAD_BEEF);
    send_item(OP_READ, 5'd16, 32'h0);
    send_item(OP_READ, 5'd15, 32'h0);
    send_item(OP_SEARCH, 5'd0, 32'h1111_1110);
    send_item(OP_REMOVE, 5'd15, 32'h0);
    send_item(OP_INSERT, 5'd3, 32'hA5A5_A5A5);
    send_item(OP_REMOVE, 5'd0, 32'h0);
    wait_for_results();
  endtask

  // Holds the output off for a long stretch while the sender keeps offering
  // transactions, so the result register fills and the input must stall.
  task automatic test_input_backpressure();
    int i;
    gap_percent = 0;
    stall_percent = 0;
    holdoff_request = 60;
    for (i = 0; i < 20; i++) begin
      if (i % 2 == 0) send_item(OP_INSERT, list_len[4:0], $urandom);
      else send_item(OP_READ, 5'd0, $urandom);
    end
    wait_for_results();
  endtask

  // Random operations. The mix swings between growing and shrinking spells so
  // the list spends time both near empty and near full; most positions are in
  // range, a tenth are anywhere in the field. Searches mostly look for a
  // value that is stored, and a small value pool makes duplicates common.
  task automatic test_random_ops(input int n_items, input int idle_pct, input int stall_pct);
    int k;
    int roll;
    int len;
    bit growing;
    op_t op;
    logic [4:0] pos;
    logic [31:0] val;
    gap_percent = idle_pct;
    stall_percent = stall_pct;
    growing = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (k % 30 == 0) growing = ($urandom_range(2) != 0) || (list_len < 4);
      len = list_len;
      roll = $urandom_range(99);
      if (growing) begin
        if (roll < 55) op = OP_INSERT;
        else if (roll < 70) op = OP_READ;
        else if (roll < 80) op = OP_REMOVE;
        else op = OP_SEARCH;
      end else begin
        if (roll < 20) op = OP_INSERT;
        else if (roll < 35) op = OP_READ;
        else if (roll < 80) op = OP_REMOVE;
        else op = OP_SEARCH;
      end
      roll = $urandom_range(99);
      if (roll < 10) pos = 5'($urandom_range(31));
      else if (roll < 25) pos = 5'd0;
      else if (op == OP_INSERT) pos = 5'($urandom_range(len));
      else pos = (len == 0) ? 5'd0 : 5'($urandom_range(len - 1));
      roll = $urandom_range(99);
      if (op == OP_SEARCH && len > 0 && roll < 60) val = list_words[4'($urandom_range(len - 1))];
      else if (roll < 30) val = $urandom_range(7);
      else if (roll < 35) val = 32'hFFFF_FFFF;
      else if (roll < 40) val = 32'h0;
      else val = $urandom;
      send_item(op, pos, val);
    end
    wait_for_results();
  endtask

  initial begin
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list_edges();
    test_full_list();
    test_input_backpressure();
    test_random_ops(150, 0, 0);
    test_random_ops(150, 64, 0);
    test_random_ops(150, 0, 64);
    test_random_ops(150, 24, 24);
    wait_for_results();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS indexed_list_queue");
    end else begin
      $display("FAIL indexed_list_queue");
    end
    $finish;
  end

endmodule
